### design/rrt_pkg.sv
// Shared types and codes for the registered range table.
package rrt_pkg;

	typedef enum logic [3:0] {
		ACT_OVERLAP   = 4'd0,
		ACT_INS_PIN   = 4'd1,
		ACT_INS_MAP   = 4'd2,
		ACT_CONTAINS  = 4'd3,
		ACT_PIN_BASE  = 4'd4,
		ACT_MAP_BASE  = 4'd5,
		ACT_ERASE_PIN = 4'd6,
		ACT_ERASE_MAP = 4'd7,
		ACT_TRANSLATE = 4'd8
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH,
		FSM_OUT
	} fsm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture request, clear scan trackers
		logic scan;     // examine the entry under the scan pointer
		logic finish;   // commit the table update and form the result
	} rrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;     // scan pointer is at the final entry
	} rrt_stat_t;

endpackage

### design/registered_range_table.sv
// Top level of the registered range table: controller plus scan datapath.
//
//  Channel | Handshake          | Beat fields
//  --------+--------------------+---------------------------------------------
//  request | in_valid/in_stall  | action, address, length, device_address
//  result  | out_valid/out_stall| hit, status, device_result
//
// After acceptance, a request scans the table one entry at a time, then commits
// the update and registers the result, then presents the result beat. The
// accepting edge also fetches the first entry, and the block takes the next
// request in the cycle after the result beat.
// Reset clears the valid bits and the controller; entry contents need none.
// A stalled result holds the block; the next request is taken once it leaves.
module registered_range_table #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [63:0] address,
	input  logic [63:0] length,
	input  logic [63:0] device_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [1:0]  status,
	output logic [63:0] device_result
);

	rrt_pkg::rrt_cmd_t  cmd;
	rrt_pkg::rrt_stat_t stat;

	// The controller sequences capture, scan, commit and output.
	rrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the table and tracks the nearest entries during a scan.
	rrt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.address        (address),
		.length         (length),
		.device_address (device_address),
		.hit            (hit),
		.status         (status),
		.device_result  (device_result)
	);

endmodule

### design/rrt_ctrl.sv
// Controller state machine for the registered range table.
module rrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  rrt_pkg::rrt_stat_t stat,
	output rrt_pkg::rrt_cmd_t  cmd
);

	rrt_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrt_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrt_pkg::FSM_IDLE: begin
				if (in_valid) state_d = rrt_pkg::FSM_SCAN;
			end
			rrt_pkg::FSM_SCAN: begin
				if (stat.last) state_d = rrt_pkg::FSM_FINISH;
			end
			rrt_pkg::FSM_FINISH: state_d = rrt_pkg::FSM_OUT;
			rrt_pkg::FSM_OUT: begin
				if (!out_stall) state_d = rrt_pkg::FSM_IDLE;
			end
			default: state_d = rrt_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			rrt_pkg::FSM_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			rrt_pkg::FSM_SCAN: cmd.scan = 1'b1;
			rrt_pkg::FSM_FINISH: cmd.finish = 1'b1;
			rrt_pkg::FSM_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

### design/rrt_datapath.sv
// Entry storage and the per-entry scan datapath of the registered range table.
module rrt_datapath #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rrt_pkg::rrt_cmd_t  cmd,
	output rrt_pkg::rrt_stat_t stat,
	input  logic [3:0]         action,
	input  logic [63:0]        address,
	input  logic [63:0]        length,
	input  logic [63:0]        device_address,
	output logic               hit,
	output logic [1:0]         status,
	output logic [63:0]        device_result
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     mapped_mem [TABLE_ENTRIES];
	logic [63:0]              start_mem  [TABLE_ENTRIES];
	logic [63:0]              end_mem    [TABLE_ENTRIES];
	logic [63:0]              dev_mem    [TABLE_ENTRIES];

	logic [3:0]  act_q;
	logic [63:0] addr_q, rend_q, dev_q;
	logic [IW-1:0] ptr_q;

	// Trackers, index 0 pinned, index 1 mapped.
	logic [1:0]  pred_have_q, succ_have_q;
	logic [63:0] pred_start_q [2];
	logic [63:0] pred_end_q   [2];
	logic [63:0] succ_start_q [2];
	logic [1:0]  base_hit_q;
	logic [IW-1:0] base_idx_q [2];
	logic        free_have_q;
	logic [IW-1:0] free_idx_q;

	logic hit_q;
	logic [1:0] status_q;
	logic [63:0] result_q;

	// Entry read in the cycle before its scan cycle.
	logic [IW-1:0] rd_addr;
	logic          e_map_s1;
	logic [63:0]   e_start_s1, e_end_s1;

	logic e_valid, e_map, k;
	logic [63:0] e_start, e_end;
	logic [IW-1:0] nfound;

	// The load cycle fetches entry 0; each scan cycle fetches the following entry.
	assign rd_addr = cmd.load ? '0 : ptr_q + IW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.scan) begin
			e_map_s1   <= mapped_mem[rd_addr];
			e_start_s1 <= start_mem[rd_addr];
			e_end_s1   <= end_mem[rd_addr];
		end
	end

	assign e_valid = valid_q[ptr_q];
	assign e_map   = e_map_s1;
	assign e_start = e_start_s1;
	assign e_end   = e_end_s1;
	assign k       = e_map;
	assign stat.last = (ptr_q == IW'(TABLE_ENTRIES - 1));

	// Request and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			addr_q <= address;
			rend_q <= address + length - 64'd1;
			dev_q  <= device_address;
			ptr_q  <= '0;
			pred_have_q <= '0;
			succ_have_q <= '0;
			base_hit_q <= '0;
			free_have_q <= 1'b0;
		end else if (cmd.scan) begin
			ptr_q <= ptr_q + IW'(1);
			if (!e_valid) begin
				if (!free_have_q) begin
					free_have_q <= 1'b1;
					free_idx_q  <= ptr_q;
				end
			end else begin
				if (e_start == addr_q) begin
					base_hit_q[k] <= 1'b1;
					base_idx_q[k] <= ptr_q;
				end
				if (e_start >= addr_q) begin
					if (!succ_have_q[k] || e_start < succ_start_q[k]) begin
						succ_have_q[k]  <= 1'b1;
						succ_start_q[k] <= e_start;
					end
				end else if (!pred_have_q[k] || e_start > pred_start_q[k]) begin
					pred_have_q[k]  <= 1'b1;
					pred_start_q[k] <= e_start;
					pred_end_q[k]   <= e_end;
				end
			end
		end
	end

	logic ov0, ov1, ct0, ct1, is_map;
	assign ov0 = (succ_have_q[0] && succ_start_q[0] <= rend_q) ||
		(pred_have_q[0] && pred_end_q[0] >= addr_q);
	assign ov1 = (succ_have_q[1] && succ_start_q[1] <= rend_q) ||
		(pred_have_q[1] && pred_end_q[1] >= addr_q);
	assign ct0 = base_hit_q[0] || (pred_have_q[0] && addr_q <= pred_end_q[0]);
	assign ct1 = base_hit_q[1] || (pred_have_q[1] && addr_q <= pred_end_q[1]);
	assign is_map = (act_q == rrt_pkg::ACT_INS_MAP) || (act_q == rrt_pkg::ACT_ERASE_MAP);
	assign nfound = base_idx_q[is_map];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish) begin
			if ((act_q == rrt_pkg::ACT_INS_PIN || act_q == rrt_pkg::ACT_INS_MAP) &&
			    !base_hit_q[is_map] && free_have_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if ((act_q == rrt_pkg::ACT_ERASE_PIN || act_q == rrt_pkg::ACT_ERASE_MAP) &&
			    base_hit_q[is_map]) begin
				valid_q[nfound] <= 1'b0;
			end
		end
	end

	// Entry payload, written on insert.
	always_ff @(posedge clk) begin
		if (cmd.finish && (act_q == rrt_pkg::ACT_INS_PIN || act_q == rrt_pkg::ACT_INS_MAP) &&
		    !base_hit_q[is_map] && free_have_q) begin
			mapped_mem[free_idx_q] <= is_map;
			start_mem[free_idx_q]  <= addr_q;
			end_mem[free_idx_q]    <= rend_q;
			dev_mem[free_idx_q]    <= is_map ? dev_q : 64'd0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hit_q <= 1'b0;
			status_q <= rrt_pkg::ST_OK;
			result_q <= '0;
			case (act_q)
				rrt_pkg::ACT_OVERLAP: begin
					if (ov0 || ov1) begin
						hit_q <= 1'b1;
						status_q <= rrt_pkg::ST_DUP;
					end
				end
				rrt_pkg::ACT_INS_PIN, rrt_pkg::ACT_INS_MAP: begin
					if (base_hit_q[is_map]) begin
						hit_q <= 1'b1;
						status_q <= rrt_pkg::ST_DUP;
					end else if (!free_have_q) begin
						status_q <= rrt_pkg::ST_FULL;
					end
				end
				rrt_pkg::ACT_CONTAINS: hit_q <= ct0 || ct1;
				rrt_pkg::ACT_PIN_BASE: hit_q <= base_hit_q[0];
				rrt_pkg::ACT_MAP_BASE: hit_q <= base_hit_q[1];
				rrt_pkg::ACT_ERASE_PIN, rrt_pkg::ACT_ERASE_MAP: hit_q <= base_hit_q[is_map];
				rrt_pkg::ACT_TRANSLATE: begin
					hit_q <= base_hit_q[1];
					if (base_hit_q[1]) result_q <= dev_mem[base_idx_q[1]];
				end
				default: ;
			endcase
		end
	end

	assign hit = hit_q;
	assign status = status_q;
	assign device_result = result_q;

endmodule
